// File: src/pfbb_pkg.sv
`timescale 1ns / 1ps

package pfbb_pkg;

	localparam int WIDTH = 128;
	localparam int PAGES = 8;
	localparam int DEPTH = WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);

	typedef struct packed {
		logic          valid;
		logic [AW-1:0] addr1;
		logic [3:0]    page1;
		logic [7:0]    data1;
		logic [7:0]    mask1;
		logic          has2;
		logic [AW-1:0] addr2;
		logic [3:0]    page2;
		logic [7:0]    data2;
		logic [7:0]    mask2;
		logic [6:0]    col;
		logic          invert;
		logic          refresh;
	} run_t;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_WR1   = 4'b0100,
		ST_WR2   = 4'b1000
	} state_t;

	function automatic logic [7:0] merge(input logic [7:0] old, input logic [7:0] data,
		input logic [7:0] mask, input logic inv);
		logic [7:0] d;
		d = inv ? ~data : data;
		return (old & ~mask) | (d & mask);
	endfunction

endpackage

// File: src/page_framebuffer_bit_blit.sv
`timescale 1ns / 1ps
// an accepted item is latched into run_q as its first byte is read; ST_WR1 merges,
// writes and registers that byte to the outputs, ST_WR2 does the same for a second page
// busy holds off new items meanwhile; an item that writes nothing leaves the block idle
// reset: busy stays high while the frame memory is cleared
// results carry no back-pressure: each strobe lasts one cycle

module page_framebuffer_bit_blit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [8:0] column,
	input  logic signed [8:0] row,
	input  logic [7:0]        bits,
	input  logic [3:0]        bit_count,
	input  logic              invert,
	input  logic              refresh,
	output logic              strobe,
	output logic [2:0]        page,
	output logic [6:0]        out_column,
	output logic [7:0]        pixel_byte,
	output logic              last
);

	pfbb_pkg::state_t           state_q;
	pfbb_pkg::run_t             run;
	pfbb_pkg::run_t             run_q;
	logic [pfbb_pkg::AW-1:0]    clr_q;
	logic                       we;
	logic [pfbb_pkg::AW-1:0]    waddr;
	logic [7:0]                 wdata;
	logic [pfbb_pkg::AW-1:0]    raddr;
	logic [7:0]                 rdata;
	logic                       accept;

	pfbb_decode u_decode (
		.column    (column),
		.row       (row),
		.bits      (bits),
		.bit_count (bit_count),
		.invert    (invert),
		.refresh   (refresh),
		.run       (run)
	);

	pfbb_ram #(
		.AW (pfbb_pkg::AW),
		.DW (8)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy   = (state_q != pfbb_pkg::ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = 8'h00;
		raddr = run.addr1;
		unique case (state_q)
			pfbb_pkg::ST_CLEAR: begin
				we = 1'b1;
			end
			pfbb_pkg::ST_IDLE: begin
				raddr = run.addr1;
			end
			pfbb_pkg::ST_WR1: begin
				we    = 1'b1;
				waddr = run_q.addr1;
				wdata = pfbb_pkg::merge(rdata, run_q.data1, run_q.mask1, run_q.invert);
				raddr = run_q.addr2;
			end
			pfbb_pkg::ST_WR2: begin
				we    = 1'b1;
				waddr = run_q.addr2;
				wdata = pfbb_pkg::merge(rdata, run_q.data2, run_q.mask2, run_q.invert);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfbb_pkg::ST_CLEAR;
			clr_q   <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				pfbb_pkg::ST_CLEAR: begin
					clr_q <= clr_q + pfbb_pkg::AW'(1);
					if (clr_q == pfbb_pkg::AW'(pfbb_pkg::DEPTH - 1)) begin
						state_q <= pfbb_pkg::ST_IDLE;
					end
				end
				pfbb_pkg::ST_IDLE: begin
					if (accept && run.valid) begin
						state_q <= pfbb_pkg::ST_WR1;
					end
				end
				pfbb_pkg::ST_WR1: begin
					strobe  <= run_q.refresh;
					state_q <= run_q.has2 ? pfbb_pkg::ST_WR2 : pfbb_pkg::ST_IDLE;
				end
				pfbb_pkg::ST_WR2: begin
					strobe  <= run_q.refresh;
					state_q <= pfbb_pkg::ST_IDLE;
				end
				default: begin
					state_q <= pfbb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_q <= run;
		end
		if (state_q == pfbb_pkg::ST_WR1) begin
			page       <= run_q.page1[2:0];
			out_column <= run_q.col;
			pixel_byte <= wdata;
			last       <= !run_q.has2;
		end else if (state_q == pfbb_pkg::ST_WR2) begin
			page       <= run_q.page2[2:0];
			out_column <= run_q.col;
			pixel_byte <= wdata;
			last       <= 1'b1;
		end
	end

endmodule

// File: src/pfbb_ram.sv
`timescale 1ns / 1ps

module pfbb_ram #(
	parameter int AW = 10,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/pfbb_decode.sv
`timescale 1ns / 1ps

module pfbb_decode (
	input  logic signed [8:0] column,
	input  logic signed [8:0] row,
	input  logic [7:0]        bits,
	input  logic [3:0]        bit_count,
	input  logic              invert,
	input  logic              refresh,
	output pfbb_pkg::run_t    run
);

	logic [3:0]        cnt;
	logic              in_frame;
	logic signed [4:0] vis;
	logic [3:0]        neg;
	logic [3:0]        pg1;
	logic [4:0]        pg2;
	logic [2:0]        off;
	logic [3:0]        fin;

	always_comb begin
		cnt = (bit_count > 4'd8) ? 4'd8 : bit_count;
		in_frame = (cnt != 4'd0) && (column >= 9'sd0) && (column < pfbb_pkg::WIDTH)
			&& (row >= -9'sd8) && (row < pfbb_pkg::PAGES * 8);
		vis = $signed({1'b0, cnt}) + $signed(row[4:0]);
		neg = 4'(-row);
		pg1 = row[6:3];
		pg2 = {1'b0, pg1} + 5'd1;
		off = row[2:0];
		fin = {1'b0, off} + cnt;

		run.col     = column[6:0];
		run.invert  = invert;
		run.refresh = refresh;
		run.page2   = pg2[3:0];
		run.addr2   = pfbb_pkg::AW'(32'(column[7:0]) * 32'(pfbb_pkg::PAGES) + 32'(pg2));
		run.data2   = bits >> (4'd8 - {1'b0, off});
		run.mask2   = 8'hFF >> (5'd16 - {1'b0, fin});
		run.has2    = 1'b0;

		if (row[8]) begin
			run.valid = in_frame && (vis > 5'sd0);
			run.page1 = 4'd0;
			run.addr1 = pfbb_pkg::AW'(32'(column[7:0]) * 32'(pfbb_pkg::PAGES));
			run.data1 = bits >> neg;
			run.mask1 = 8'hFF >> (4'd8 - vis[3:0]);
		end else begin
			run.valid = in_frame;
			run.page1 = pg1;
			run.addr1 = pfbb_pkg::AW'(32'(column[7:0]) * 32'(pfbb_pkg::PAGES) + 32'(pg1));
			run.data1 = bits << off;
			if (fin <= 4'd8) begin
				run.mask1 = (8'hFF << off) & (8'hFF >> (4'd8 - fin));
			end else begin
				run.mask1 = 8'hFF << off;
				run.has2  = 32'(pg2) < pfbb_pkg::PAGES;
			end
		end
	end

endmodule
